// File: rtl/core/hre_pkg.sv
`timescale 1ns / 1ps

package hre_pkg;

	localparam int STORE_DEPTH  = 16;
	localparam int RECORD_MAX   = 16;
	localparam int IDX_W        = $clog2(STORE_DEPTH);
	localparam int LEN_W        = IDX_W + 1;
	localparam int PC_W         = 5;
	localparam int CHAR_W       = 7;

	localparam logic [CHAR_W-1:0] CH_COLON = 7'h3a;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_ONE   = 7'h31;
	localparam logic [CHAR_W-1:0] CH_F     = 7'h46;
	localparam logic [CHAR_W-1:0] CH_NL    = 7'h0a;

	// which record byte feeds the hex digit of a step
	typedef enum logic [2:0] {
		SEL_CONST,
		SEL_LEN,
		SEL_ADDR_HI,
		SEL_ADDR_LO,
		SEL_ZERO,
		SEL_DATA,
		SEL_CHK
	} sel_t;

	typedef enum logic [1:0] {
		OP_NEXT,
		OP_LOOP,
		OP_EOL,
		OP_STOP
	} op_t;

	typedef struct packed {
		sel_t              sel;
		logic              nib_hi;
		logic [CHAR_W-1:0] ch;
		op_t               op;
		logic [PC_W-1:0]   target;
	} uword_t;

	typedef struct packed {
		logic              busy;
		sel_t              sel;
		logic              nib_hi;
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic [IDX_W-1:0]  idx;
	} hre_ctrl_t;

	localparam logic [PC_W-1:0] PC_DATA_HI = 5'd9;

	// record program: colon, length, address, type, data loop, checksum, newline,
	// then the end record when the image is finished
	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{sel: SEL_CONST, nib_hi: 1'b0, ch: CH_ZERO, op: OP_NEXT, target: '0};
		case (pc) inside
			5'd0:           w.ch = CH_COLON;
			5'd1:           begin w.sel = SEL_LEN;     w.nib_hi = 1'b1; end
			5'd2:           w.sel = SEL_LEN;
			5'd3:           begin w.sel = SEL_ADDR_HI; w.nib_hi = 1'b1; end
			5'd4:           w.sel = SEL_ADDR_HI;
			5'd5:           begin w.sel = SEL_ADDR_LO; w.nib_hi = 1'b1; end
			5'd6:           w.sel = SEL_ADDR_LO;
			5'd7:           begin w.sel = SEL_ZERO;    w.nib_hi = 1'b1; end
			5'd8:           w.sel = SEL_ZERO;
			5'd9:           begin w.sel = SEL_DATA;    w.nib_hi = 1'b1; end
			5'd10:          begin w.sel = SEL_DATA; w.op = OP_LOOP; w.target = PC_DATA_HI; end
			5'd11:          begin w.sel = SEL_CHK;     w.nib_hi = 1'b1; end
			5'd12:          w.sel = SEL_CHK;
			5'd13:          begin w.ch = CH_NL; w.op = OP_EOL; end
			5'd14:          w.ch = CH_COLON;
			[5'd15:5'd21]:  w.ch = CH_ZERO;
			5'd22:          w.ch = CH_ONE;
			[5'd23:5'd24]:  w.ch = CH_F;
			5'd25:          begin w.ch = CH_NL; w.op = OP_STOP; end
			default:        w.op = OP_STOP;
		endcase
		return w;
	endfunction

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
		logic [CHAR_W-1:0] c;
		if (nib < 4'd10)
			c = CH_ZERO + CHAR_W'(nib);
		else
			c = 7'h61 + CHAR_W'(nib - 4'd10);
		return c;
	endfunction

endpackage

// File: rtl/core/hre_if.sv
`timescale 1ns / 1ps

interface hre_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface hre_text_if;
	logic       valid;
	logic       ready;
	logic [6:0] text_char;
	logic       run_last;

	modport source (output valid, output text_char, output run_last, input ready);
	modport sink   (input valid, input text_char, input run_last, output ready);
endinterface

// File: rtl/core/hre_seq.sv
`timescale 1ns / 1ps

module hre_seq
	import hre_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             adv,
	input  logic [LEN_W-1:0] len,
	input  logic             end_pend,
	output hre_ctrl_t        ctrl
);

	logic             busy_q;
	logic [PC_W-1:0]  pc_q;
	logic [IDX_W-1:0] idx_q;
	uword_t           uw;
	logic             more_data;

	assign uw        = ucode(pc_q);
	assign more_data = ({1'b0, idx_q} + LEN_W'(1)) < len;

	always_comb begin
		ctrl.busy   = busy_q;
		ctrl.sel    = uw.sel;
		ctrl.nib_hi = uw.nib_hi;
		ctrl.ch     = uw.ch;
		ctrl.idx    = idx_q;
		ctrl.last   = (uw.op == OP_STOP) || ((uw.op == OP_EOL) && !end_pend);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= '0;
			idx_q  <= '0;
		end else if (busy_q && adv) begin
			case (uw.op)
				OP_NEXT: pc_q <= pc_q + PC_W'(1);
				OP_LOOP: begin
					if (more_data) begin
						idx_q <= idx_q + IDX_W'(1);
						pc_q  <= uw.target;
					end else begin
						pc_q <= pc_q + PC_W'(1);
					end
				end
				OP_EOL: begin
					if (end_pend)
						pc_q <= pc_q + PC_W'(1);
					else
						busy_q <= 1'b0;
				end
				OP_STOP: busy_q <= 1'b0;
				default: busy_q <= 1'b0;
			endcase
		end
	end

endmodule

// File: rtl/core/intel_hex_record_encoder.sv
`timescale 1ns / 1ps

// byte stream in on data, hex text out on text, one ascii character per beat
// bytes are held until RECORD_BYTES are buffered or a beat with final_byte set
// arrives; that beat starts a type 00 record with lowercase digits and newline
// a final beat also appends the end record ":00000001FF" and a newline
// run_last marks the last character caused by an input beat
// a beat that only buffers its byte is taken with no output
// a record of n bytes gives 12 + 2n characters, the end record 12 more
// the first character passes the sequencer and the single output register to
// text, then one character a cycle while text is ready; data.ready is low
// while the record program runs; a stall on text freezes the sequencer with
// the character held; the user must write base_address via cfg_we/cfg_wdata
// only while the block is idle, which the block itself does not enforce
// reset clears the buffer count, offset, running sum and base address
module intel_hex_record_encoder
	import hre_pkg::*;
#(
	parameter int RECORD_BYTES = RECORD_MAX
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_wdata,
	hre_byte_if.sink          data,
	hre_text_if.source        text
);

	logic [7:0]        store_q [STORE_DEPTH];
	logic [LEN_W-1:0]  fill_q;
	logic [15:0]       offset_q;
	logic [7:0]        rsum_q;
	logic [15:0]       base_q;

	logic [LEN_W-1:0]  len_q;
	logic [15:0]       addr_q;
	logic [7:0]        dsum_q;
	logic              endp_q;

	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;

	hre_ctrl_t         ctrl;
	logic              accept;
	logic              adv;
	logic              start;
	logic [LEN_W-1:0]  fill_nx;
	logic [7:0]        rsum_nx;
	logic [7:0]        chk;
	logic [7:0]        cur_byte;
	logic [3:0]        nib;
	logic [CHAR_W-1:0] cur_char;

	assign accept  = data.valid && data.ready;
	assign adv     = !out_valid_q || text.ready;
	assign fill_nx = fill_q + LEN_W'(1);
	assign rsum_nx = rsum_q + data.data_byte;
	assign start   = accept && ((fill_nx >= LEN_W'(RECORD_BYTES)) || data.final_byte);

	assign data.ready     = !ctrl.busy;
	assign text.valid     = out_valid_q;
	assign text.text_char = out_char_q;
	assign text.run_last  = out_last_q;

	// two's complement of length, address bytes and data sum
	assign chk = 8'd0 - (8'(len_q) + addr_q[15:8] + addr_q[7:0] + dsum_q);

	always_comb begin
		case (ctrl.sel)
			SEL_LEN:     cur_byte = 8'(len_q);
			SEL_ADDR_HI: cur_byte = addr_q[15:8];
			SEL_ADDR_LO: cur_byte = addr_q[7:0];
			SEL_DATA:    cur_byte = store_q[ctrl.idx];
			SEL_CHK:     cur_byte = chk;
			default:     cur_byte = 8'h00;
		endcase
		nib      = ctrl.nib_hi ? cur_byte[7:4] : cur_byte[3:0];
		cur_char = (ctrl.sel == SEL_CONST) ? ctrl.ch : hex_char(nib);
	end

	hre_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.adv      (adv),
		.len      (len_q),
		.end_pend (endp_q),
		.ctrl     (ctrl)
	);

	always_ff @(posedge clk) begin
		if (accept)
			store_q[fill_q[IDX_W-1:0]] <= data.data_byte;
		if (start) begin
			len_q  <= fill_nx;
			addr_q <= base_q + offset_q;
			dsum_q <= rsum_nx;
		end
		if (ctrl.busy && adv) begin
			out_char_q <= cur_char;
			out_last_q <= ctrl.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			offset_q    <= '0;
			rsum_q      <= '0;
			base_q      <= '0;
			endp_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				base_q <= cfg_wdata;
			if (start) begin
				fill_q   <= '0;
				rsum_q   <= '0;
				endp_q   <= data.final_byte;
				offset_q <= data.final_byte ? 16'h0000 : offset_q + 16'(fill_nx);
			end else if (accept) begin
				fill_q <= fill_nx;
				rsum_q <= rsum_nx;
			end
			if (adv)
				out_valid_q <= ctrl.busy;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(text.valid) |-> $past(ctrl.busy))
		else $error("text beat without a running record");

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < LEN_W'(RECORD_BYTES))
		else $error("buffer count reached a full record");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && data.final_byte |=> ctrl.busy)
		else $error("final byte did not start a record");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.busy && adv && ctrl.last |=> !ctrl.busy && text.valid && text.run_last)
		else $error("sequencer kept running past the last character");

endmodule
